>>> rtl/mrf_pkg.sv
// Package for the Modbus RTU request framer: request codes, controller
// states, command/status structs, frame tables and the CRC-16 byte step.
// No dependencies.
`timescale 1ns / 1ps

package mrf_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS    = 2'd0,
    CFG_CRC_POLYNOMIAL    = 2'd1,
    CFG_MEASURE_REGISTER  = 2'd2,
    CFG_SETPOINT_REGISTER = 2'd3
  } cfg_index_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } ctl_state_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IDX_W      = 5;

  localparam logic [7:0]  DEVICE_ADDRESS_RST    = 8'h11;
  localparam logic [15:0] CRC_POLYNOMIAL_RST    = 16'hA001;
  localparam logic [15:0] MEASURE_REGISTER_RST  = 16'd2000;
  localparam logic [15:0] SETPOINT_REGISTER_RST = 16'd2300;
  localparam logic [15:0] CRC_INIT              = 16'hFFFF;

  localparam logic [IDX_W-1:0] LEN_READ  = 5'd8;
  localparam logic [IDX_W-1:0] LEN_WRITE = 5'd23;
  localparam logic [IDX_W-1:0] LEN_STOP  = 5'd11;

  typedef struct packed {
    logic take_in;
    logic start;
    logic advance;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic req_ok;
    logic load_ok;
    logic final_byte;
  } ctl_status_t;

  function automatic logic [IDX_W-1:0] frame_len(input req_kind_t req);
    logic [IDX_W-1:0] len;
    case (req)
      REQ_READ:  len = LEN_READ;
      REQ_WRITE: len = LEN_WRITE;
      REQ_STOP:  len = LEN_STOP;
      default:   len = LEN_READ;
    endcase
    return len;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ poly;
      else      c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_byte(
    input req_kind_t        req,
    input logic [IDX_W-1:0] idx,
    input logic [7:0]       addr,
    input logic [15:0]      mreg,
    input logic [15:0]      sreg,
    input logic [15:0]      sp,
    input logic             rising,
    input logic [15:0]      crc
  );
    logic [7:0] b;
    logic [7:0] ext;
    ext = {8{sp[15]}};
    b   = 8'h00;
    case (req)
      REQ_READ: begin
        case (idx)
          5'd0:    b = addr;
          5'd1:    b = 8'h03;
          5'd2:    b = mreg[15:8];
          5'd3:    b = mreg[7:0];
          5'd5:    b = 8'h02;
          5'd6:    b = crc[7:0];
          5'd7:    b = crc[15:8];
          default: b = 8'h00;
        endcase
      end
      REQ_STOP: begin
        case (idx)
          5'd0:    b = addr;
          5'd1:    b = 8'h10;
          5'd2:    b = sreg[15:8];
          5'd3:    b = sreg[7:0];
          5'd5:    b = 8'h01;
          5'd6:    b = 8'h02;
          5'd9:    b = crc[7:0];
          5'd10:   b = crc[15:8];
          default: b = 8'h00;
        endcase
      end
      REQ_WRITE: begin
        case (idx)
          5'd0:    b = addr;
          5'd1:    b = 8'h10;
          5'd2:    b = sreg[15:8];
          5'd3:    b = sreg[7:0];
          5'd5:    b = 8'h06;
          5'd6:    b = 8'h0C;
          5'd7:    b = 8'h01;
          5'd8:    b = 8'h01;
          5'd10:   b = 8'hFF;
          5'd15:   b = sp[15:8];
          5'd16:   b = sp[7:0];
          5'd17:   b = ext;
          5'd18:   b = ext;
          5'd19:   b = rising ? 8'hC8 : 8'h38;
          5'd20:   b = rising ? 8'h00 : 8'hFF;
          5'd21:   b = crc[7:0];
          5'd22:   b = crc[15:8];
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/mrf_if.sv
// Handshake interfaces: request channel and frame byte channel.
// Standalone, no package dependency.
`timescale 1ns / 1ps

interface mrf_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] setpoint_centi;
  logic signed [31:0] current_centi;

  modport source (output valid, output req_type, output setpoint_centi,
                  output current_centi, input ready);
  modport sink   (input valid, input req_type, input setpoint_centi,
                  input current_centi, output ready);
endinterface

interface mrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/mrf_ctrl.sv
// Framer controller: idle/send state machine issuing start and advance.
// Depends on mrf_pkg.
`timescale 1ns / 1ps

module mrf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrf_pkg::ctl_status_t st,
  output mrf_pkg::ctl_cmd_t    cmd
);
  import mrf_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.take_in = 1'b1;
        if (st.in_valid && st.req_ok) begin
          cmd.start = 1'b1;
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (st.load_ok) begin
          cmd.advance = 1'b1;
          if (st.final_byte) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/mrf_datapath.sv
// Framer datapath: config registers, held request, byte counter, CRC-16
// and the output register. Depends on mrf_pkg and mrf_if.
`timescale 1ns / 1ps

module mrf_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [mrf_pkg::CFG_DATA_W-1:0]    cfg_data,
  mrf_req_if.sink                           in_req,
  mrf_byte_if.source                        out_frame,
  input  mrf_pkg::ctl_cmd_t                 cmd,
  output mrf_pkg::ctl_status_t              st
);
  import mrf_pkg::*;

  logic [7:0]       dev_addr_r;
  logic [15:0]      poly_r;
  logic [15:0]      mreg_r;
  logic [15:0]      sreg_r;

  req_kind_t        req_r;
  logic [15:0]      sp_r;
  logic             rising_r;
  logic [IDX_W-1:0] idx_r;
  logic [15:0]      crc_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_valid_r;

  logic [IDX_W-1:0] len;
  logic [7:0]       cur_byte;
  logic             is_data;
  logic             rising_nxt;

  assign len      = frame_len(req_r);
  assign is_data  = idx_r < (len - 5'd2);
  assign cur_byte = frame_byte(req_r, idx_r, dev_addr_r, mreg_r, sreg_r, sp_r,
                               rising_r, crc_r);
  assign rising_nxt = $signed({{16{in_req.setpoint_centi[15]}}, in_req.setpoint_centi})
                      > in_req.current_centi;

  assign st.in_valid   = in_req.valid;
  assign st.req_ok     = (req_kind_t'(in_req.req_type) != REQ_NONE);
  assign st.load_ok    = !out_valid_r || out_frame.ready;
  assign st.final_byte = (idx_r == (len - 5'd1));

  assign in_req.ready       = cmd.take_in;
  assign out_frame.valid    = out_valid_r;
  assign out_frame.out_byte = out_byte_r;
  assign out_frame.last     = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEVICE_ADDRESS_RST;
      poly_r     <= CRC_POLYNOMIAL_RST;
      mreg_r     <= MEASURE_REGISTER_RST;
      sreg_r     <= SETPOINT_REGISTER_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_DEVICE_ADDRESS:    dev_addr_r <= cfg_data[7:0];
        CFG_CRC_POLYNOMIAL:    poly_r     <= cfg_data;
        CFG_MEASURE_REGISTER:  mreg_r     <= cfg_data;
        CFG_SETPOINT_REGISTER: sreg_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // held request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r    <= REQ_READ;
      sp_r     <= '0;
      rising_r <= 1'b0;
    end else if (cmd.start) begin
      req_r    <= req_kind_t'(in_req.req_type);
      sp_r     <= in_req.setpoint_centi;
      rising_r <= rising_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      out_byte_r <= cur_byte;
      out_last_r <= st.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx_r <= '0;
        crc_r <= CRC_INIT;
      end else if (cmd.advance) begin
        if (st.final_byte) begin
          idx_r <= '0;
          crc_r <= CRC_INIT;
        end else begin
          idx_r <= idx_r + 5'd1;
          if (is_data) crc_r <= crc_step(crc_r, cur_byte, poly_r);
        end
      end
      if (cmd.advance)          out_valid_r <= 1'b1;
      else if (out_frame.ready) out_valid_r <= 1'b0;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < LEN_WRITE)
    else $error("byte counter past longest frame");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (!out_valid_r || out_frame.ready))
    else $error("output register overwritten before transfer");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (idx_r == '0 && crc_r == CRC_INIT))
    else $error("frame scratch not cleared on start");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && st.final_byte) |=> (out_last_r && out_valid_r && idx_r == '0))
    else $error("final byte not marked last");

endmodule

>>> rtl/modbus_request_framer_top.sv
// Modbus RTU request framer, top level: controller plus datapath.
// Depends on mrf_pkg, mrf_if, mrf_ctrl and mrf_datapath.
//
// Usage:
//   in_req    : one request per transfer (req_type, setpoint_centi,
//               current_centi). Code 3 is taken and dropped.
//   out_frame : one frame byte per transfer in transmit order, CRC-16 low
//               byte then high byte, last set on the CRC high byte.
//   cfg_*     : register writes (address, polynomial, measure and setpoint
//               register), only while no frame is in flight.
// Timing: a request is taken at its accepting edge, which loads the held
//   request and moves the controller to send; its first byte is then
//   loaded into the output register once that register is free. A frame
//   is 8, 11 or 23 bytes long, and after its last byte the controller
//   returns to idle to take the next request.
// The next request is taken once the last byte sits in the output
//   register. A stalled sink holds the byte and halts the counter and CRC.
// Reset (synchronous, rst_n low) empties the output register, returns to
//   idle and restores the configuration reset values.
`timescale 1ns / 1ps

module modbus_request_framer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [mrf_pkg::CFG_DATA_W-1:0] cfg_data,
  mrf_req_if.sink                        in_req,
  mrf_byte_if.source                     out_frame
);
  import mrf_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t st;

  mrf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  mrf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .out_frame (out_frame),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
